// ----- rtl/framed_command_parser_top_macros.svh -----
`ifndef FRAMED_COMMAND_PARSER_TOP_MACROS_SVH
`define FRAMED_COMMAND_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CMDP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmdp check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CMDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmdp check failed");

`endif

// ----- rtl/cmdp_pkg.sv -----
package cmdp_pkg;

  localparam int FRAME_CAPACITY_DEF = 16;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MOVE  = 8'h4D;

  localparam logic [8:0] VALUE_SAT = 9'd256;

  typedef enum logic [1:0] {
    MODE_STOP     = 2'd0,
    MODE_READY    = 2'd1,
    MODE_COUNTING = 2'd2,
    MODE_MOVING   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    WORD_STOP,
    WORD_START,
    WORD_COUNT
  } word_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_MODE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic [1:0] new_mode;
  } item_t;

  typedef struct packed {
    logic       reply;
    mode_t      mode_now;
    logic       stop_motor;
    logic       stop_timer;
    logic       restart_count;
    logic       offset_valid;
    logic [7:0] offset;
  } result_t;

  // True when b is the character expected at frame position pos of the given word.
  // Position 1 holds the first letter of the word.
  function automatic logic word_char_ok(word_t word, logic [2:0] pos, logic [7:0] b);
    logic [7:0] exp_char;
    logic       in_word;
    exp_char = 8'h00;
    in_word  = 1'b0;
    unique case (word)
      WORD_STOP: begin
        in_word = 1'b1;
        case (pos)
          3'd1: exp_char = "S";
          3'd2: exp_char = "T";
          3'd3: exp_char = "O";
          3'd4: exp_char = "P";
          default: in_word = 1'b0;
        endcase
      end
      WORD_START: begin
        in_word = 1'b1;
        case (pos)
          3'd1: exp_char = "S";
          3'd2: exp_char = "T";
          3'd3: exp_char = "A";
          3'd4: exp_char = "R";
          3'd5: exp_char = "T";
          default: in_word = 1'b0;
        endcase
      end
      WORD_COUNT: begin
        in_word = 1'b1;
        case (pos)
          3'd1: exp_char = "B";
          3'd2: exp_char = "R";
          3'd3: exp_char = "O";
          3'd4: exp_char = "J";
          3'd5: exp_char = "I";
          default: in_word = 1'b0;
        endcase
      end
      default: in_word = 1'b0;
    endcase
    return in_word && (exp_char == b);
  endfunction

endpackage

// ----- rtl/cmdp_in_if.sv -----
interface cmdp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic [1:0] new_mode;

  modport source (output valid, output req_type, output rx_byte, output new_mode,
                  input ready);
  modport sink (input valid, input req_type, input rx_byte, input new_mode,
                output ready);
endinterface

// ----- rtl/cmdp_out_if.sv -----
interface cmdp_out_if;
  logic       valid;
  logic       ready;
  logic       reply;
  logic [1:0] mode_now;
  logic       stop_motor;
  logic       stop_timer;
  logic       restart_count;
  logic       offset_valid;
  logic [7:0] offset;

  modport source (output valid, output reply, output mode_now, output stop_motor,
                  output stop_timer, output restart_count, output offset_valid,
                  output offset, input ready);
  modport sink (input valid, input reply, input mode_now, input stop_motor,
                input stop_timer, input restart_count, input offset_valid,
                input offset, output ready);
endinterface

// ----- rtl/framed_command_parser_top.sv -----
// A closing byte's reply passes through the input register and then the reply register.
// Throughput: one request per cycle while the reply register can load; frame state: one pass per byte.
// Requests other than a closing byte produce no reply and only update the frame or mode.
// Reset (rst, synchronous, active high) sets stop mode, clears the frame and empties
// the input and reply registers.
module framed_command_parser_top #(
  parameter int FRAME_CAPACITY = cmdp_pkg::FRAME_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cmdp_in_if.sink    req,
  cmdp_out_if.source rsp
);
  import cmdp_pkg::*;
  `include "framed_command_parser_top_macros.svh"

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  logic    res_valid;
  result_t res;

  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_item.req_type <= req.req_type;
      s1_item.rx_byte  <= req.rx_byte;
      s1_item.new_mode <= req.new_mode;
    end
  end

  cmdp_frame_parser #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_valid && advance),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  cmdp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_valid && res_valid),
    .res      (res),
    .can_load (advance),
    .rsp      (rsp)
  );

  `CMDP_ASSERT_NOW(a_offset_move, rsp.valid && rsp.offset_valid, rsp.restart_count && !rsp.reply && rsp.mode_now == MODE_MOVING)
  `CMDP_ASSERT_NOW(a_stop_pair, rsp.valid && rsp.stop_motor, rsp.stop_timer && !rsp.reply && rsp.mode_now == MODE_STOP)
  `CMDP_ASSERT_NOW(a_error_quiet, rsp.valid && rsp.reply, !rsp.stop_motor && !rsp.restart_count && rsp.offset == 8'd0)
  `CMDP_ASSERT_NEXT(a_hold_request, s1_valid && !advance, s1_valid && $stable(s1_item))

endmodule

// ----- rtl/cmdp_frame_parser.sv -----
module cmdp_frame_parser #(
  parameter int FRAME_CAPACITY = cmdp_pkg::FRAME_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cmdp_pkg::item_t   item,
  output logic              res_valid,
  output cmdp_pkg::result_t res
);
  import cmdp_pkg::*;

  localparam int PW = $clog2(FRAME_CAPACITY);
  localparam logic [PW-1:0] POS_LAST = PW'(FRAME_CAPACITY - 1);

  mode_t         mode;
  logic [PW-1:0] frame_pos;
  logic          stop_prefix_ok;
  logic          start_prefix_ok;
  logic          count_prefix_ok;
  logic          move_prefix_ok;
  logic          digits_ok;
  logic [8:0]    move_value;

  mode_t         mode_next;
  logic [PW-1:0] frame_pos_next;
  logic          stop_prefix_ok_next;
  logic          start_prefix_ok_next;
  logic          count_prefix_ok_next;
  logic          move_prefix_ok_next;
  logic          digits_ok_next;
  logic [8:0]    move_value_next;

  logic          is_open;
  logic          is_close;
  logic          is_digit;
  logic [PW-1:0] p;
  logic          pos_small;
  logic [2:0]    pos3;
  logic          frame_full;
  logic          frame_good;
  logic [11:0]   acc;
  logic [8:0]    acc_sat;
  logic          value_ok;

  assign is_open   = (item.rx_byte == CH_OPEN);
  assign is_close  = (item.rx_byte == CH_CLOSE);
  assign is_digit  = (item.rx_byte >= CH_ZERO) && (item.rx_byte <= CH_NINE);
  assign p         = is_open ? '0 : frame_pos;
  assign pos_small = ((p >> 3) == '0);
  assign pos3      = p[2:0];
  assign frame_full = (p >= POS_LAST);
  assign frame_good = !frame_full && (p != '0);

  assign acc = {move_value, 3'b000} + {2'b00, move_value, 1'b0}
             + {8'd0, 4'(item.rx_byte - CH_ZERO)};
  assign acc_sat  = (acc >= 12'(VALUE_SAT)) ? VALUE_SAT : acc[8:0];
  assign value_ok = (move_value != 9'd0) && !move_value[8];

  always_comb begin
    mode_next            = mode;
    frame_pos_next       = frame_pos;
    stop_prefix_ok_next  = stop_prefix_ok;
    start_prefix_ok_next = start_prefix_ok;
    count_prefix_ok_next = count_prefix_ok;
    move_prefix_ok_next  = move_prefix_ok;
    digits_ok_next       = digits_ok;
    move_value_next      = move_value;

    res_valid         = 1'b0;
    res.reply         = 1'b1;
    res.stop_motor    = 1'b0;
    res.stop_timer    = 1'b0;
    res.restart_count = 1'b0;
    res.offset_valid  = 1'b0;
    res.offset        = 8'd0;

    if (item.req_type == REQ_MODE) begin
      mode_next = mode_t'(item.new_mode);
    end else if (!is_close) begin
      if (is_open) begin
        frame_pos_next = '0;
      end
      if (!frame_full) begin
        if (p == '0) begin
          stop_prefix_ok_next  = is_open;
          start_prefix_ok_next = is_open;
          count_prefix_ok_next = is_open;
          move_prefix_ok_next  = is_open;
          digits_ok_next       = 1'b1;
          move_value_next      = 9'd0;
        end else begin
          stop_prefix_ok_next  = stop_prefix_ok && pos_small
                                 && word_char_ok(WORD_STOP, pos3, item.rx_byte);
          start_prefix_ok_next = start_prefix_ok && pos_small
                                 && word_char_ok(WORD_START, pos3, item.rx_byte);
          count_prefix_ok_next = count_prefix_ok && pos_small
                                 && word_char_ok(WORD_COUNT, pos3, item.rx_byte);
          if (p == PW'(1)) begin
            move_prefix_ok_next = move_prefix_ok && (item.rx_byte == CH_MOVE);
          end else if (is_digit) begin
            move_value_next = acc_sat;
          end else begin
            digits_ok_next = 1'b0;
          end
        end
        frame_pos_next = p + PW'(1);
      end
    end else begin
      res_valid = 1'b1;
      if (frame_good) begin
        if (stop_prefix_ok && p == PW'(5)) begin
          mode_next      = MODE_STOP;
          res.stop_motor = 1'b1;
          res.stop_timer = 1'b1;
          res.reply      = 1'b0;
        end else begin
          unique case (mode) inside
            MODE_STOP: begin
              if (start_prefix_ok && p == PW'(6)) begin
                mode_next = MODE_READY;
                res.reply = 1'b0;
              end
            end
            MODE_READY: begin
              if (count_prefix_ok && p == PW'(6)) begin
                mode_next = MODE_COUNTING;
                res.reply = 1'b0;
              end else if (move_prefix_ok && p >= PW'(3) && digits_ok && value_ok) begin
                mode_next         = MODE_MOVING;
                res.offset        = move_value[7:0];
                res.offset_valid  = 1'b1;
                res.restart_count = 1'b1;
                res.reply         = 1'b0;
              end
            end
            MODE_COUNTING, MODE_MOVING: begin
              res.reply = 1'b1;
            end
            default: begin
              res.reply = 1'b1;
            end
          endcase
        end
      end
      frame_pos_next       = '0;
      stop_prefix_ok_next  = 1'b0;
      start_prefix_ok_next = 1'b0;
      count_prefix_ok_next = 1'b0;
      move_prefix_ok_next  = 1'b0;
      digits_ok_next       = 1'b1;
      move_value_next      = 9'd0;
    end
    res.mode_now = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_STOP;
      frame_pos       <= '0;
      stop_prefix_ok  <= 1'b0;
      start_prefix_ok <= 1'b0;
      count_prefix_ok <= 1'b0;
      move_prefix_ok  <= 1'b0;
      digits_ok       <= 1'b1;
      move_value      <= 9'd0;
    end else if (en) begin
      mode            <= mode_next;
      frame_pos       <= frame_pos_next;
      stop_prefix_ok  <= stop_prefix_ok_next;
      start_prefix_ok <= start_prefix_ok_next;
      count_prefix_ok <= count_prefix_ok_next;
      move_prefix_ok  <= move_prefix_ok_next;
      digits_ok       <= digits_ok_next;
      move_value      <= move_value_next;
    end
  end

endmodule

// ----- rtl/cmdp_out_reg.sv -----
module cmdp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cmdp_pkg::result_t res,
  output logic              can_load,
  cmdp_out_if.source        rsp
);
  import cmdp_pkg::*;

  logic    valid;
  result_t data;

  assign can_load = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      data <= res;
    end
  end

  assign rsp.valid         = valid;
  assign rsp.reply         = data.reply;
  assign rsp.mode_now      = data.mode_now;
  assign rsp.stop_motor    = data.stop_motor;
  assign rsp.stop_timer    = data.stop_timer;
  assign rsp.restart_count = data.restart_count;
  assign rsp.offset_valid  = data.offset_valid;
  assign rsp.offset        = data.offset;

endmodule
